// File: sv/pmau_pkg.sv
// shared constants, codes and controller/datapath interface types for the modular unit
`default_nettype none

package pmau_pkg;

    localparam int unsigned ResW = 30;

    localparam logic [ResW-1:0] Modulus   = 30'd1000000007;
    localparam logic [ResW-1:0] FermatExp = 30'd1000000005;
    // floor(2^60 / modulus), the barrett reciprocal
    localparam logic [ResW:0]   BarrettMu = 31'((64'd1 << 60) / 64'd1000000007);

    // weights of bits 30 and 60 of a 64-bit magnitude, already reduced
    localparam logic [ResW-1:0] Pow30Mod = 30'((64'd1 << 30) % 64'd1000000007);
    localparam logic [ResW-1:0] Pow60Mod = 30'((64'd1 << 60) % 64'd1000000007);

    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_POW = 3'd4;
    localparam logic [2:0] OP_INV = 3'd5;

    // phases of one modular multiply on the shared multiplier
    localparam logic [2:0] MM_IDLE = 3'd0;
    localparam logic [2:0] MM_PROD = 3'd1;
    localparam logic [2:0] MM_EST  = 3'd2;
    localparam logic [2:0] MM_QP   = 3'd3;
    localparam logic [2:0] MM_FIX  = 3'd4;

    localparam logic [2:0] SEL_A_B       = 3'd0;
    localparam logic [2:0] SEL_ACC_BASE  = 3'd1;
    localparam logic [2:0] SEL_BASE_BASE = 3'd2;
    localparam logic [2:0] SEL_A_ACC     = 3'd3;
    localparam logic [2:0] SEL_FOLD_A    = 3'd4;
    localparam logic [2:0] SEL_FOLD_B    = 3'd5;

    localparam logic [2:0] DST_RES  = 3'd0;
    localparam logic [2:0] DST_ACC  = 3'd1;
    localparam logic [2:0] DST_BASE = 3'd2;
    localparam logic [2:0] DST_RA   = 3'd3;
    localparam logic [2:0] DST_RB   = 3'd4;

    localparam logic [1:0] RES_ADD  = 2'd0;
    localparam logic [1:0] RES_SUB  = 2'd1;
    localparam logic [1:0] RES_ZERO = 2'd2;
    localparam logic [1:0] RES_ACC  = 2'd3;

    typedef struct packed {
        logic       load;
        logic       red_sign;
        logic       res_wr;
        logic [1:0] res_src;
        logic       set_bad;
        logic       pow_init;
        logic       pow_fermat;
        logic       pow_base_b;
        logic       exp_clr_lsb;
        logic       exp_shift;
        logic [2:0] mm_phase;
        logic [2:0] mm_sel;
        logic [2:0] mm_dst;
        logic       out_load;
    } pmau_cmd_t;

    typedef struct packed {
        logic [2:0] op;
        logic       b_neg;
        logic       exp_zero;
        logic       exp_lsb;
    } pmau_status_t;

endpackage

`default_nettype wire

// File: sv/pmau_datapath.sv
// datapath: operand folding, shared barrett multiplier, power registers and output register
`default_nettype none

module pmau_datapath (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic [2:0]             operation,
    input  wire logic signed [63:0]     operand_a,
    input  wire logic signed [63:0]     operand_b,
    input  wire pmau_pkg::pmau_cmd_t    cmd,
    output pmau_pkg::pmau_status_t      status,
    output logic [pmau_pkg::ResW-1:0]   residue,
    output logic                        bad_exponent
);
    import pmau_pkg::*;

    logic [2:0]      op_reg;
    logic [63:0]     braw_reg;
    logic [63:0]     mag_a_reg;
    logic [63:0]     mag_b_reg;
    logic            neg_a_reg;
    logic            neg_b_reg;
    logic [ResW-1:0] ra_reg;
    logic [ResW-1:0] rb_reg;
    logic [ResW-1:0] acc_reg;
    logic [ResW-1:0] base_reg;
    logic [ResW-1:0] res_reg;
    logic            bad_reg;
    logic [63:0]     exp_reg;
    logic [61:0]     mult_reg;
    logic [31:0]     plo_reg;
    logic [ResW-1:0] out_res_reg;
    logic            out_bad_reg;

    logic [63:0]     ua;
    logic [63:0]     ub;
    logic [63:0]     mag_a_in;
    logic [63:0]     mag_b_in;
    logic [ResW:0]   sum_w;
    logic [ResW:0]   diff_w;
    logic [ResW-1:0] add_val;
    logic [ResW-1:0] sub_val;
    logic [63:0]     fold_mag;
    logic [33:0]     fold_top;
    logic [ResW:0]   mul_x;
    logic [ResW:0]   mul_y;
    logic [61:0]     mul_add;
    logic [61:0]     mul_out;
    logic [31:0]     r0;
    logic [31:0]     r1;
    logic [31:0]     r2;
    logic [ResW-1:0] fix_val;

    localparam logic [31:0] Mod32 = {2'b00, Modulus};

    function automatic logic [ResW-1:0] fix_sign(input logic [ResW-1:0] r, input logic neg);
        logic [ResW-1:0] v;
        v = r;
        if (neg && (r != '0))
        begin
            v = Modulus - r;
        end
        return v;
    endfunction

    always_comb
    begin
        ua       = operand_a;
        ub       = operand_b;
        mag_a_in = ua[63] ? (~ua + 64'd1) : ua;
        mag_b_in = ub[63] ? (~ub + 64'd1) : ub;

        sum_w   = {1'b0, ra_reg} + {1'b0, rb_reg};
        add_val = (sum_w >= {1'b0, Modulus}) ? ResW'(sum_w - {1'b0, Modulus}) : sum_w[ResW-1:0];
        diff_w  = {1'b0, ra_reg} - {1'b0, rb_reg};
        sub_val = diff_w[ResW] ? ResW'(diff_w + {1'b0, Modulus}) : diff_w[ResW-1:0];

        // magnitude = top*2^60 + mid*2^30 + low, folded to below 2^58
        fold_mag = (cmd.mm_sel == SEL_FOLD_B) ? mag_b_reg : mag_a_reg;
        fold_top = {30'b0, fold_mag[63:60]} * {4'b0, Pow60Mod};

        mul_add = '0;
        unique case (cmd.mm_phase)
            MM_PROD:
            begin
                unique case (cmd.mm_sel)
                    SEL_A_B:
                    begin
                        mul_x = {1'b0, ra_reg};
                        mul_y = {1'b0, rb_reg};
                    end
                    SEL_ACC_BASE:
                    begin
                        mul_x = {1'b0, acc_reg};
                        mul_y = {1'b0, base_reg};
                    end
                    SEL_BASE_BASE:
                    begin
                        mul_x = {1'b0, base_reg};
                        mul_y = {1'b0, base_reg};
                    end
                    SEL_A_ACC:
                    begin
                        mul_x = {1'b0, ra_reg};
                        mul_y = {1'b0, acc_reg};
                    end
                    SEL_FOLD_A, SEL_FOLD_B:
                    begin
                        mul_x   = {1'b0, fold_mag[59:30]};
                        mul_y   = {1'b0, Pow30Mod};
                        mul_add = {28'b0, fold_top} + {32'b0, fold_mag[ResW-1:0]};
                    end
                    default:
                    begin
                        mul_x = '0;
                        mul_y = '0;
                    end
                endcase
            end
            // quotient estimate from the top bits of the product
            MM_EST:
            begin
                mul_x = mult_reg[59:29];
                mul_y = BarrettMu;
            end
            MM_QP:
            begin
                mul_x = mult_reg[61:31];
                mul_y = {1'b0, Modulus};
            end
            default:
            begin
                mul_x = '0;
                mul_y = '0;
            end
        endcase
        mul_out = {31'b0, mul_x} * {31'b0, mul_y};

        // barrett remainder is below three times the modulus
        r0      = plo_reg - mult_reg[31:0];
        r1      = (r0 >= Mod32) ? (r0 - Mod32) : r0;
        r2      = (r1 >= Mod32) ? (r1 - Mod32) : r1;
        fix_val = r2[ResW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg      <= '0;
            braw_reg    <= '0;
            mag_a_reg   <= '0;
            mag_b_reg   <= '0;
            neg_a_reg   <= 1'b0;
            neg_b_reg   <= 1'b0;
            ra_reg      <= '0;
            rb_reg      <= '0;
            acc_reg     <= '0;
            base_reg    <= '0;
            res_reg     <= '0;
            bad_reg     <= 1'b0;
            exp_reg     <= '0;
            mult_reg    <= '0;
            plo_reg     <= '0;
            out_res_reg <= '0;
            out_bad_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                op_reg    <= operation;
                braw_reg  <= ub;
                mag_a_reg <= mag_a_in;
                mag_b_reg <= mag_b_in;
                neg_a_reg <= ua[63];
                neg_b_reg <= ub[63];
                ra_reg    <= '0;
                rb_reg    <= '0;
                bad_reg   <= 1'b0;
            end
            if (cmd.red_sign)
            begin
                ra_reg <= fix_sign(ra_reg, neg_a_reg);
                rb_reg <= fix_sign(rb_reg, neg_b_reg);
            end
            if (cmd.res_wr)
            begin
                unique case (cmd.res_src)
                    RES_ADD:  res_reg <= add_val;
                    RES_SUB:  res_reg <= sub_val;
                    RES_ZERO: res_reg <= '0;
                    RES_ACC:  res_reg <= acc_reg;
                endcase
            end
            if (cmd.set_bad)
            begin
                bad_reg <= 1'b1;
            end
            if (cmd.pow_init)
            begin
                acc_reg  <= ResW'(1);
                base_reg <= cmd.pow_base_b ? rb_reg : ra_reg;
                exp_reg  <= cmd.pow_fermat ? {34'b0, FermatExp} : braw_reg;
            end
            if (cmd.exp_clr_lsb)
            begin
                exp_reg[0] <= 1'b0;
            end
            if (cmd.exp_shift)
            begin
                exp_reg <= exp_reg >> 1;
            end
            if ((cmd.mm_phase == MM_PROD) || (cmd.mm_phase == MM_EST) ||
                (cmd.mm_phase == MM_QP))
            begin
                mult_reg <= mul_out + mul_add;
            end
            if (cmd.mm_phase == MM_EST)
            begin
                plo_reg <= mult_reg[31:0];
            end
            if (cmd.mm_phase == MM_FIX)
            begin
                unique case (cmd.mm_dst)
                    DST_RES:  res_reg  <= fix_val;
                    DST_ACC:  acc_reg  <= fix_val;
                    DST_BASE: base_reg <= fix_val;
                    DST_RA:   ra_reg   <= fix_val;
                    DST_RB:   rb_reg   <= fix_val;
                    default:  res_reg  <= fix_val;
                endcase
            end
            if (cmd.out_load)
            begin
                out_res_reg <= res_reg;
                out_bad_reg <= bad_reg;
            end
        end
    end

    assign status.op       = op_reg;
    assign status.b_neg    = braw_reg[63];
    assign status.exp_zero = (exp_reg == '0);
    assign status.exp_lsb  = exp_reg[0];

    assign residue      = out_res_reg;
    assign bad_exponent = out_bad_reg;

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.red_sign |=> (ra_reg < Modulus) && (rb_reg < Modulus))
        else $error("operand reduction left the residue range");

    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.mm_phase == MM_PROD) |=> (mult_reg[61:60] == 2'b00))
        else $error("multiplier output above the barrett input range");

    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.mm_phase == MM_FIX) |-> (fix_val < Modulus))
        else $error("barrett correction did not reach the residue range");
`endif

endmodule

`default_nettype wire

// File: sv/pmau_ctrl.sv
// controller: sequences reduction, dispatch, square-and-multiply and result handoff
`default_nettype none

module pmau_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    input  wire pmau_pkg::pmau_status_t status,
    output pmau_pkg::pmau_cmd_t         cmd
);
    import pmau_pkg::*;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_SIGN     = 4'd2;
    localparam logic [3:0] S_DISPATCH = 4'd3;
    localparam logic [3:0] S_PCHK     = 4'd4;
    localparam logic [3:0] S_M1       = 4'd5;
    localparam logic [3:0] S_M2       = 4'd6;
    localparam logic [3:0] S_M3       = 4'd7;
    localparam logic [3:0] S_M4       = 4'd8;
    localparam logic [3:0] S_DONE     = 4'd9;

    logic [3:0]      state_reg;
    logic [3:0]      state_next;
    logic [2:0]      sel_reg;
    logic [2:0]      sel_next;
    logic [2:0]      dst_reg;
    logic [2:0]      dst_next;
    logic            out_valid_reg;
    logic            out_valid_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        sel_next   = sel_reg;
        dst_next   = dst_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    // operand a is folded and reduced first, then operand b
                    cmd.load   = 1'b1;
                    sel_next   = SEL_FOLD_A;
                    dst_next   = DST_RA;
                    state_next = S_M1;
                end
            end
            S_SIGN:
            begin
                cmd.red_sign = 1'b1;
                state_next   = S_DISPATCH;
            end
            S_DISPATCH:
            begin
                unique case (status.op)
                    OP_ADD:
                    begin
                        cmd.res_wr  = 1'b1;
                        cmd.res_src = RES_ADD;
                        state_next  = S_DONE;
                    end
                    OP_SUB:
                    begin
                        cmd.res_wr  = 1'b1;
                        cmd.res_src = RES_SUB;
                        state_next  = S_DONE;
                    end
                    OP_MUL:
                    begin
                        sel_next   = SEL_A_B;
                        dst_next   = DST_RES;
                        state_next = S_M1;
                    end
                    OP_DIV:
                    begin
                        cmd.pow_init   = 1'b1;
                        cmd.pow_fermat = 1'b1;
                        cmd.pow_base_b = 1'b1;
                        state_next     = S_PCHK;
                    end
                    OP_POW:
                    begin
                        if (status.b_neg)
                        begin
                            cmd.set_bad = 1'b1;
                            cmd.res_wr  = 1'b1;
                            cmd.res_src = RES_ZERO;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            cmd.pow_init = 1'b1;
                            state_next   = S_PCHK;
                        end
                    end
                    OP_INV:
                    begin
                        cmd.pow_init   = 1'b1;
                        cmd.pow_fermat = 1'b1;
                        state_next     = S_PCHK;
                    end
                    default:
                    begin
                        cmd.res_wr  = 1'b1;
                        cmd.res_src = RES_ZERO;
                        state_next  = S_DONE;
                    end
                endcase
            end
            S_PCHK:
            begin
                priority if (status.exp_zero)
                begin
                    if (status.op == OP_DIV)
                    begin
                        sel_next   = SEL_A_ACC;
                        dst_next   = DST_RES;
                        state_next = S_M1;
                    end
                    else
                    begin
                        cmd.res_wr  = 1'b1;
                        cmd.res_src = RES_ACC;
                        state_next  = S_DONE;
                    end
                end
                else if (status.exp_lsb)
                begin
                    // multiply into the accumulator; the square follows unless the exponent is now zero
                    cmd.exp_clr_lsb = 1'b1;
                    sel_next        = SEL_ACC_BASE;
                    dst_next        = DST_ACC;
                    state_next      = S_M1;
                end
                else
                begin
                    cmd.exp_shift = 1'b1;
                    sel_next      = SEL_BASE_BASE;
                    dst_next      = DST_BASE;
                    state_next    = S_M1;
                end
            end
            S_M1:
            begin
                cmd.mm_phase = MM_PROD;
                cmd.mm_sel   = sel_reg;
                state_next   = S_M2;
            end
            S_M2:
            begin
                cmd.mm_phase = MM_EST;
                state_next   = S_M3;
            end
            S_M3:
            begin
                cmd.mm_phase = MM_QP;
                state_next   = S_M4;
            end
            S_M4:
            begin
                cmd.mm_phase = MM_FIX;
                cmd.mm_dst   = dst_reg;
                unique case (dst_reg)
                    DST_RES:
                    begin
                        state_next = S_DONE;
                    end
                    DST_RA:
                    begin
                        sel_next   = SEL_FOLD_B;
                        dst_next   = DST_RB;
                        state_next = S_M1;
                    end
                    DST_RB:
                    begin
                        state_next = S_SIGN;
                    end
                    default:
                    begin
                        state_next = S_PCHK;
                    end
                endcase
            end
            S_DONE:
            begin
                // wait for a free output register
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sel_reg       <= SEL_A_B;
            dst_reg       <= DST_RES;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sel_reg       <= sel_next;
            dst_reg       <= dst_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("result overwrote an output transaction not yet taken");

    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_M1) && (dst_reg == DST_RA))
        else $error("accepted transaction did not start reduction");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_M1) |=> ((state_reg == S_M2) ##1 (state_reg == S_M3)))
        else $error("modular multiply phases out of order");
`endif

endmodule

`default_nettype wire

// File: sv/prime_modular_arithmetic_unit.sv
// top level of the modular arithmetic unit modulo 1000000007
//
//  channel  direction  handshake            payload
//  input    in         in_valid/in_ready    operation, operand_a, operand_b
//  output   out        out_valid/out_ready  residue, bad_exponent
//
// one transaction at a time; after input accept each operand is folded and barrett-reduced
// on the shared multiplier, then sign fix and dispatch; add, subtract, negative exponent and
// unused codes then finish, multiply adds one modular multiply, power one square per exponent
// shift and one multiply per set bit, inverse raises to modulus-2 and divide multiplies by it
// in_ready returns with out_valid; a new transaction can be taken while a result waits
// rst_n clears all registers asynchronously; no clearing pass is needed
`default_nettype none

module prime_modular_arithmetic_unit (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [2:0]           operation,
    input  wire logic signed [63:0]   operand_a,
    input  wire logic signed [63:0]   operand_b,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [pmau_pkg::ResW-1:0] residue,
    output logic                      bad_exponent
);
    import pmau_pkg::*;

    pmau_cmd_t    cmd;
    pmau_status_t status;

    pmau_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    pmau_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .operation    (operation),
        .operand_a    (operand_a),
        .operand_b    (operand_b),
        .cmd          (cmd),
        .status       (status),
        .residue      (residue),
        .bad_exponent (bad_exponent)
    );

endmodule

`default_nettype wire

// File: dv/tb_prime_modular_arithmetic_unit.sv
// self-checking testbench for the modular arithmetic unit modulo 1000000007
module tb_prime_modular_arithmetic_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import pmau_pkg::*;

    localparam logic [2:0]  OP_SPARE_LO = 3'd6;
    localparam logic [2:0]  OP_SPARE_HI = 3'd7;
    localparam logic [63:0] PRIME       = 64'(Modulus);
    localparam logic [63:0] INV_EXP     = 64'(FermatExp);
    localparam logic [63:0] S64_MAX     = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] S64_MIN     = 64'h8000_0000_0000_0000;
    localparam logic [63:0] MINUS_ONE   = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [ResW-1:0] residue;
        logic            bad_exponent;
    } field_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [2:0]           operation = OP_ADD;
    logic signed [63:0]   operand_a = '0;
    logic signed [63:0]   operand_b = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [ResW-1:0]      residue;
    logic                 bad_exponent;

    field_result_t pending_results[$];
    int unsigned   op_count[8];
    int unsigned   results_checked = 0;
    int unsigned   bad_flags_seen = 0;
    int unsigned   error_count = 0;

    prime_modular_arithmetic_unit uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .operation    (operation),
        .operand_a    (operand_a),
        .operand_b    (operand_b),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .residue      (residue),
        .bad_exponent (bad_exponent)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ---------------------------------------------------------------- predictor

    // mathematical remainder of a signed 64-bit value
    function automatic logic [63:0] fold_to_field(input logic [63:0] v);
        logic [63:0] mag;
        logic [63:0] r;
        mag = v[63] ? (~v) + 64'd1 : v;
        r = mag % PRIME;
        if (v[63] && r != 0)
            r = PRIME - r;
        return r;
    endfunction

    function automatic logic [63:0] mod_mul(input logic [63:0] x, input logic [63:0] y);
        return (x * y) % PRIME;
    endfunction

    function automatic logic [63:0] mod_pow(input logic [63:0] base, input logic [63:0] e);
        logic [63:0] acc;
        acc = 64'd1;
        while (e != 0)
        begin
            if (e[0])
                acc = mod_mul(acc, base);
            base = mod_mul(base, base);
            e = e >> 1;
        end
        return acc;
    endfunction

    function automatic field_result_t predict_residue(input logic [2:0] op,
                                                      input logic [63:0] raw_a,
                                                      input logic [63:0] raw_b);
        field_result_t want;
        logic [63:0]   a;
        logic [63:0]   b;
        logic [63:0]   r;
        a = fold_to_field(raw_a);
        b = fold_to_field(raw_b);
        r = 64'd0;
        want.bad_exponent = 1'b0;
        case (op)
            OP_ADD: r = (a + b) % PRIME;
            OP_SUB: r = (a + PRIME - b) % PRIME;
            OP_MUL: r = mod_mul(a, b);
            OP_DIV: r = mod_mul(a, mod_pow(b, INV_EXP));
            OP_POW:
            begin
                if (raw_b[63])
                    want.bad_exponent = 1'b1;
                else
                    r = mod_pow(a, raw_b);
            end
            OP_INV: r = mod_pow(a, INV_EXP);
            default: r = 64'd0;
        endcase
        want.residue = r[ResW-1:0];
        return want;
    endfunction

    // ---------------------------------------------------------------- stimulus helpers

    // mostly back to back, some short gaps, a few long ones
    function automatic int unsigned draw_gap();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r < 12)
            return 0;
        if (r < 18)
            return $urandom_range(1, 4);
        return $urandom_range(10, 80);
    endfunction

    function automatic logic [63:0] rand_operand();
        logic [63:0] v;
        case ($urandom_range(0, 7))
            0, 1, 2, 3: v = {$urandom, $urandom};
            4: v = 64'($signed($urandom_range(0, 2000)) - 1000);
            5:
            begin
                // near a multiple of the modulus, either sign
                v = PRIME * 64'($urandom_range(0, 1 << 20)) + 64'($urandom_range(0, 4)) - 64'd2;
                if ($urandom_range(0, 1))
                    v = -v;
            end
            6:
            begin
                case ($urandom_range(0, 7))
                    0: v = S64_MIN;
                    1: v = S64_MAX;
                    2: v = 64'd0;
                    3: v = MINUS_ONE;
                    4: v = 64'd1;
                    5: v = PRIME;
                    6: v = -PRIME;
                    default: v = PRIME - 64'd1;
                endcase
            end
            default: v = 64'($signed($urandom));
        endcase
        return v;
    endfunction

    // exponents of every bit length, a share of them negative
    function automatic logic [63:0] rand_exponent();
        logic [63:0] raw;
        int unsigned width;
        raw = {$urandom, $urandom};
        if ($urandom_range(0, 7) == 0)
            return raw | S64_MIN;
        width = $urandom_range(0, 63);
        return raw & ((64'd1 << width) - 64'd1);
    endfunction

    // ---------------------------------------------------------------- shared tasks

    task automatic send_operation(input logic [2:0] op, input logic [63:0] a,
                                  input logic [63:0] b);
        int unsigned gap;
        operation <= op;
        operand_a <= a;
        operand_b <= b;
        in_valid  <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_results.push_back(predict_residue(op, a, b));
        op_count[op]++;
        gap = draw_gap();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // hold the input side until every outstanding transaction has come back
    task automatic wait_for_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // result checker
    initial
    begin
        field_result_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("unexpected transaction: residue %0d bad_exponent %0b",
                           residue, bad_exponent);
                    error_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    results_checked++;
                    if (bad_exponent)
                        bad_flags_seen++;
                    if (residue !== want.residue)
                    begin
                        $error("residue mismatch: expected %0d, actual %0d",
                               want.residue, residue);
                        error_count++;
                    end
                    if (bad_exponent !== want.bad_exponent)
                    begin
                        $error("bad_exponent mismatch: expected %0b, actual %0b",
                               want.bad_exponent, bad_exponent);
                        error_count++;
                    end
                end
            end
        end
    end

    // receiver stalls: bursts of ready broken by gaps
    initial
    begin
        int unsigned gap;
        @(posedge rst_n);
        forever
        begin
            out_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(50, 400)) @(posedge clk);
            else
                repeat ($urandom_range(1, 20)) @(posedge clk);
            gap = draw_gap();
            if (gap != 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    end

    // ---------------------------------------------------------------- tests

    task automatic test_directed_arithmetic();
        send_operation(OP_ADD, S64_MAX, S64_MAX);
        send_operation(OP_ADD, S64_MIN, MINUS_ONE);
        send_operation(OP_SUB, 64'd0, PRIME - 64'd1);
        send_operation(OP_SUB, S64_MIN, S64_MAX);
        send_operation(OP_MUL, S64_MAX, S64_MIN);
        send_operation(OP_MUL, MINUS_ONE, MINUS_ONE);
        send_operation(OP_MUL, PRIME, 64'd12345);
        send_operation(OP_SPARE_LO, {$urandom, $urandom}, {$urandom, $urandom});
        send_operation(OP_SPARE_HI, S64_MIN, S64_MAX);
    endtask

    task automatic test_directed_power();
        send_operation(OP_POW, 64'd0, 64'd0);
        send_operation(OP_POW, -64'd7, 64'd0);
        send_operation(OP_POW, -64'd2, 64'd3);
        send_operation(OP_POW, 64'd5, MINUS_ONE);
        send_operation(OP_POW, S64_MIN, S64_MAX);
        send_operation(OP_POW, 64'd2, PRIME - 64'd1);
        send_operation(OP_POW, S64_MAX, S64_MIN);
    endtask

    task automatic test_directed_inverse_divide();
        send_operation(OP_INV, 64'd0, 64'd0);
        send_operation(OP_INV, 64'd1, S64_MAX);
        send_operation(OP_INV, MINUS_ONE, 64'd0);
        send_operation(OP_INV, S64_MIN, 64'd0);
        send_operation(OP_DIV, 64'd7, PRIME * 64'd3);
        send_operation(OP_DIV, S64_MAX, MINUS_ONE);
        send_operation(OP_DIV, 64'd0, 64'd0);
        send_operation(OP_DIV, S64_MIN, 64'd2);
    endtask

    task automatic test_random_arithmetic(input int unsigned count);
        logic [2:0] op;
        repeat (count)
        begin
            case ($urandom_range(0, 6))
                0, 1: op = OP_ADD;
                2, 3: op = OP_SUB;
                4, 5: op = OP_MUL;
                default: op = $urandom_range(0, 1) ? OP_SPARE_HI : OP_SPARE_LO;
            endcase
            send_operation(op, rand_operand(), rand_operand());
        end
    endtask

    task automatic test_random_inverse_divide(input int unsigned count);
        repeat (count)
        begin
            if ($urandom_range(0, 1))
                send_operation(OP_DIV, rand_operand(), rand_operand());
            else
                send_operation(OP_INV, rand_operand(), rand_operand());
        end
    endtask

    task automatic test_random_power(input int unsigned count);
        repeat (count)
        begin
            send_operation(OP_POW, rand_operand(), rand_exponent());
            if ($urandom_range(0, 99) == 0)
                wait_for_results();
        end
    endtask

    // mixed traffic so that slow and fast transactions overlap in the output stage
    task automatic test_random_mixed(input int unsigned count);
        logic [2:0] op;
        repeat (count)
        begin
            op = 3'($urandom_range(0, 7));
            if (op == OP_POW)
                send_operation(op, rand_operand(), rand_exponent());
            else
                send_operation(op, rand_operand(), rand_operand());
        end
    endtask

    // ---------------------------------------------------------------- sequence

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_arithmetic();
        test_directed_power();
        test_directed_inverse_divide();
        wait_for_results();
        test_random_arithmetic(450);
        wait_for_results();
        test_random_inverse_divide(300);
        test_random_power(400);
        wait_for_results();
        test_random_mixed(200);
        wait_for_results();

        // room for any stray transaction after the last one
        repeat (800) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $error("%0d expected transactions never arrived", pending_results.size());
            error_count++;
        end

        $display("sent add %0d, sub %0d, mul %0d, div %0d, pow %0d, inv %0d, unused codes %0d",
                 op_count[OP_ADD], op_count[OP_SUB], op_count[OP_MUL], op_count[OP_DIV],
                 op_count[OP_POW], op_count[OP_INV],
                 op_count[OP_SPARE_LO] + op_count[OP_SPARE_HI]);
        $display("checked %0d results, %0d of them flagged a negative exponent",
                 results_checked, bad_flags_seen);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // watchdog
    initial
    begin
        #60_000_000;
        $display("timeout with %0d transactions outstanding", pending_results.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: files.f
sv/pmau_pkg.sv
sv/pmau_datapath.sv
sv/pmau_ctrl.sv
sv/prime_modular_arithmetic_unit.sv
dv/tb_prime_modular_arithmetic_unit.sv
